@@ design/bitmap_frame_allocator_core_macros.svh @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core_macros.svh
// Assertion macros for the bitmap frame allocator; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define BFA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define BFA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BFA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define BFA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ design/bfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Sizes, command and status codes, and word-update types shared by the
// bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // geometry
  localparam int NUM_FRAMES  = 262144;
  localparam int FRAME_BYTES = 4096;
  localparam int WORD_BITS   = 64;

  localparam int WORD_COUNT  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int WIDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int HINT_W      = $clog2(WORD_COUNT + 1);
  localparam int FIDX_W      = $clog2(NUM_FRAMES);
  localparam int FCNT_W      = $clog2(NUM_FRAMES + 1);

  // field widths
  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 64;
  localparam int LEN_W    = 64;
  localparam int STATUS_W = 2;
  localparam int FADDR_W  = 30;
  localparam int COUNT_W  = 19;

  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_BITS - 1);

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_FREE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK_USED  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SNAPSHOT   = 3'd4;

  // status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  // one read-modify-write of a bitmap word
  typedef struct packed {
    logic             set_bits;   // 1: mark used, 0: mark free
    logic             first_fit;  // touch only the lowest free bit
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } word_op_t;

  typedef struct packed {
    logic             has_free;
    logic [BIT_W-1:0] first_free;
    logic [BIT_W:0]   flips;      // bits that changed
  } word_info_t;

  localparam word_t FULL_WORD = '1;

endpackage

@@ design/bitmap_frame_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// First-fit physical frame allocator over a usage bitmap held in one RAM.
// ----------------------------------------------------------------------------
// The bitmap lives in a 4096 x 64 synchronous RAM (one bit per frame, 1 =
// used) and every allocate, free or range mark is a read-modify-write on it,
// one word at a time; one command is in flight at once, and a finished result
// waits in the output register while the next command is taken. After reset
// the core writes all-ones into every RAM word and takes no command until
// that sweep ends. An allocate scans bitmap words upward from a low-water
// mark below which every word is known full; a range mark reads, then writes
// back, each bitmap word that it covers, over the single RAM port pair.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_core_macros.svh"

module bitmap_frame_allocator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bfa_pkg::CMD_W-1:0]      cmd,
  input  logic [bfa_pkg::ADDR_W-1:0]     address,
  input  logic [bfa_pkg::LEN_W-1:0]      length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bfa_pkg::STATUS_W-1:0]   status,
  output logic [bfa_pkg::FADDR_W-1:0]    frame_address,
  output logic [bfa_pkg::COUNT_W-1:0]    free_count,
  output logic [bfa_pkg::COUNT_W-1:0]    total_available
);

  typedef enum logic [10:0] {
    S_INIT     = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_SUM      = 11'b000_0000_0100,
    S_BOUNDS   = 11'b000_0000_1000,
    S_PLAN     = 11'b000_0001_0000,
    S_ALLOC    = 11'b000_0010_0000,
    S_FREE_RD  = 11'b000_0100_0000,
    S_FREE_WR  = 11'b000_1000_0000,
    S_RANGE_RD = 11'b001_0000_0000,
    S_RANGE_WR = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_t;

  localparam logic [bfa_pkg::ADDR_W-1:0] NUM_FRAMES_A = bfa_pkg::ADDR_W'(bfa_pkg::NUM_FRAMES);
  localparam logic [bfa_pkg::FCNT_W-1:0] NUM_FRAMES_C = bfa_pkg::FCNT_W'(bfa_pkg::NUM_FRAMES);
  localparam logic [bfa_pkg::HINT_W-1:0] WORDS_H      = bfa_pkg::HINT_W'(bfa_pkg::WORD_COUNT);
  localparam logic [bfa_pkg::WIDX_W-1:0] LAST_WORD    = bfa_pkg::WIDX_W'(bfa_pkg::WORD_COUNT - 1);

  state_t state;

  // command registers
  logic [bfa_pkg::CMD_W-1:0]    cmd_q;
  logic [bfa_pkg::ADDR_W-1:0]   addr_q;
  logic [bfa_pkg::LEN_W-1:0]    len_q;
  logic [bfa_pkg::ADDR_W:0]     sum_q;       // carry in the top bit
  logic [bfa_pkg::FCNT_W-1:0]   start_q;
  logic [bfa_pkg::FCNT_W-1:0]   end_q;
  logic [bfa_pkg::FCNT_W-1:0]   last_q;
  logic [bfa_pkg::WIDX_W-1:0]   widx;
  logic [bfa_pkg::BIT_W:0]      flips;
  logic [bfa_pkg::STATUS_W-1:0] status_q;
  logic [bfa_pkg::FADDR_W-1:0]  faddr_q;

  // allocator state
  logic [bfa_pkg::WIDX_W-1:0]   init_idx;
  logic [bfa_pkg::HINT_W-1:0]   hint;        // every word below is full
  logic [bfa_pkg::HINT_W-1:0]   ptr;
  logic [bfa_pkg::WIDX_W-1:0]   rd_idx;
  logic                         rd_valid;
  logic [bfa_pkg::FCNT_W-1:0]   used_frames;
  logic [bfa_pkg::FCNT_W-1:0]   snapshot;

  // bitmap RAM
  bfa_pkg::word_t              bitmap_mem [bfa_pkg::WORD_COUNT];
  bfa_pkg::word_t              mem_rdata;
  bfa_pkg::word_t              mem_wdata;
  logic                        mem_we;
  logic                        mem_re;
  logic [bfa_pkg::WIDX_W-1:0]  mem_waddr;
  logic [bfa_pkg::WIDX_W-1:0]  mem_raddr;

  bfa_pkg::word_op_t           upd_op;
  bfa_pkg::word_t              upd_word;
  bfa_pkg::word_info_t         upd_info;

  // free-frame decode
  logic [bfa_pkg::FIDX_W-1:0]  free_frame;
  logic [bfa_pkg::WIDX_W-1:0]  free_word;
  logic                        free_ok;

  // range bounds
  logic [bfa_pkg::ADDR_W-1:0]  a_frame;
  logic [bfa_pkg::ADDR_W-1:0]  s_frame;
  logic [bfa_pkg::ADDR_W-1:0]  start_raw;
  logic [bfa_pkg::ADDR_W-1:0]  end_raw;
  logic [bfa_pkg::FCNT_W-1:0]  start_c;
  logic [bfa_pkg::FCNT_W-1:0]  end_c;
  logic [bfa_pkg::WIDX_W-1:0]  start_word;
  logic [bfa_pkg::WIDX_W-1:0]  last_word;
  logic                        mark_used;

  logic [bfa_pkg::WIDX_W+bfa_pkg::BIT_W-1:0] alloc_frame;
  logic [bfa_pkg::ADDR_W-1:0]  alloc_addr;
  logic [bfa_pkg::FCNT_W-1:0]  used_applied;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= bitmap_mem[mem_raddr];
    end
  end

  bfa_word_update u_word_update (
    .old_word (mem_rdata),
    .op       (upd_op),
    .new_word (upd_word),
    .info     (upd_info)
  );

  assign free_frame = addr_q[bfa_pkg::FRAME_SHIFT +: bfa_pkg::FIDX_W];
  assign free_word  = bfa_pkg::WIDX_W'(free_frame >> bfa_pkg::BIT_W);
  assign free_ok    = (addr_q != '0) && (addr_q[bfa_pkg::FRAME_SHIFT-1:0] == '0) &&
                      ((addr_q >> bfa_pkg::FRAME_SHIFT) < NUM_FRAMES_A);

  assign mark_used = (cmd_q == bfa_pkg::CMD_MARK_USED);

  // free marks keep whole frames only, used marks round outward
  always_comb begin
    a_frame = addr_q >> bfa_pkg::FRAME_SHIFT;
    s_frame = sum_q[bfa_pkg::ADDR_W-1:0] >> bfa_pkg::FRAME_SHIFT;
    if (mark_used) begin
      start_raw = a_frame;
      end_raw   = s_frame + bfa_pkg::ADDR_W'(|sum_q[bfa_pkg::FRAME_SHIFT-1:0]);
    end else begin
      start_raw = a_frame + bfa_pkg::ADDR_W'(|addr_q[bfa_pkg::FRAME_SHIFT-1:0]);
      end_raw   = s_frame;
    end
    start_c = (start_raw > NUM_FRAMES_A) ? NUM_FRAMES_C : start_raw[bfa_pkg::FCNT_W-1:0];
    if (sum_q[bfa_pkg::ADDR_W] || (end_raw > NUM_FRAMES_A)) begin
      end_c = NUM_FRAMES_C;
    end else begin
      end_c = end_raw[bfa_pkg::FCNT_W-1:0];
    end
  end

  assign start_word = bfa_pkg::WIDX_W'(start_q >> bfa_pkg::BIT_W);
  assign last_word  = bfa_pkg::WIDX_W'(last_q >> bfa_pkg::BIT_W);

  assign alloc_frame = {rd_idx, upd_info.first_free};
  assign alloc_addr  = bfa_pkg::ADDR_W'(alloc_frame) << bfa_pkg::FRAME_SHIFT;

  assign used_applied = mark_used ? used_frames + bfa_pkg::FCNT_W'(flips)
                                  : used_frames - bfa_pkg::FCNT_W'(flips);

  // RAM port and modify-stage control
  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = widx;
    mem_raddr  = widx;
    mem_wdata  = upd_word;
    upd_op     = '{set_bits: 1'b0, first_fit: 1'b0, lo: '0, hi: bfa_pkg::TOP_BIT};
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_idx;
        mem_wdata = bfa_pkg::FULL_WORD;
      end
      S_ALLOC: begin
        upd_op.set_bits  = 1'b1;
        upd_op.first_fit = 1'b1;
        mem_waddr        = rd_idx;
        mem_raddr        = bfa_pkg::WIDX_W'(ptr);
        if (rd_valid && upd_info.has_free) begin
          mem_we = 1'b1;
        end else if (ptr < WORDS_H) begin
          mem_re = 1'b1;
        end
      end
      S_FREE_RD: begin
        mem_raddr = free_word;
        mem_re    = free_ok;
      end
      S_FREE_WR: begin
        upd_op.lo = free_frame[bfa_pkg::BIT_W-1:0];
        upd_op.hi = free_frame[bfa_pkg::BIT_W-1:0];
        mem_waddr = free_word;
        mem_we    = 1'b1;
      end
      S_RANGE_RD: begin
        mem_re = 1'b1;
      end
      S_RANGE_WR: begin
        upd_op.set_bits = mark_used;
        upd_op.lo = (widx == start_word) ? start_q[bfa_pkg::BIT_W-1:0] : '0;
        upd_op.hi = (widx == last_word) ? last_q[bfa_pkg::BIT_W-1:0] : bfa_pkg::TOP_BIT;
        mem_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      init_idx    <= '0;
      hint        <= WORDS_H;
      used_frames <= NUM_FRAMES_C;
      snapshot    <= '0;
      out_valid   <= 1'b0;
      rd_valid    <= 1'b0;
    end else begin
      if (state == S_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= cmd;
            addr_q   <= address;
            len_q    <= length;
            status_q <= bfa_pkg::ST_OK;
            faddr_q  <= '0;
            ptr      <= hint;
            rd_valid <= 1'b0;
            case (cmd)
              bfa_pkg::CMD_ALLOC:     state <= S_ALLOC;
              bfa_pkg::CMD_FREE:      state <= S_FREE_RD;
              bfa_pkg::CMD_MARK_FREE: state <= S_SUM;
              bfa_pkg::CMD_MARK_USED: state <= S_SUM;
              bfa_pkg::CMD_SNAPSHOT: begin
                snapshot <= NUM_FRAMES_C - used_frames;
                state    <= S_OUT;
              end
              default:                state <= S_OUT;
            endcase
          end
        end
        S_ALLOC: begin
          if (rd_valid && upd_info.has_free) begin
            used_frames <= used_frames + 1'b1;
            hint        <= bfa_pkg::HINT_W'(rd_idx);
            faddr_q     <= alloc_addr[bfa_pkg::FADDR_W-1:0];
            state       <= S_OUT;
          end else if (ptr < WORDS_H) begin
            rd_idx   <= bfa_pkg::WIDX_W'(ptr);
            ptr      <= ptr + 1'b1;
            rd_valid <= 1'b1;
          end else begin
            hint     <= WORDS_H;
            status_q <= bfa_pkg::ST_NO_FREE;
            state    <= S_OUT;
          end
        end
        S_FREE_RD: begin
          if (free_ok) begin
            state <= S_FREE_WR;
          end else begin
            status_q <= bfa_pkg::ST_REJECT;
            state    <= S_OUT;
          end
        end
        S_FREE_WR: begin
          used_frames <= used_frames - bfa_pkg::FCNT_W'(upd_info.flips);
          if (bfa_pkg::HINT_W'(free_word) < hint) begin
            hint <= bfa_pkg::HINT_W'(free_word);
          end
          state <= S_OUT;
        end
        S_SUM: begin
          sum_q <= {1'b0, addr_q} + {1'b0, len_q};
          state <= S_BOUNDS;
        end
        S_BOUNDS: begin
          start_q <= start_c;
          end_q   <= end_c;
          state   <= S_PLAN;
        end
        S_PLAN: begin
          flips <= '0;
          if (start_q < end_q) begin
            widx   <= start_word;
            last_q <= end_q - 1'b1;
            if (!mark_used && (bfa_pkg::HINT_W'(start_word) < hint)) begin
              hint <= bfa_pkg::HINT_W'(start_word);
            end
            state <= S_RANGE_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_RANGE_RD: begin
          used_frames <= used_applied;
          flips       <= '0;
          state       <= S_RANGE_WR;
        end
        S_RANGE_WR: begin
          if (widx == last_word) begin
            // one more read slot would be wasted; settle the count directly
            used_frames <= mark_used ? used_frames + bfa_pkg::FCNT_W'(upd_info.flips)
                                     : used_frames - bfa_pkg::FCNT_W'(upd_info.flips);
            state <= S_OUT;
          end else begin
            flips <= upd_info.flips;
            widx  <= widx + 1'b1;
            state <= S_RANGE_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            status          <= status_q;
            frame_address   <= faddr_q;
            free_count      <= bfa_pkg::COUNT_W'(NUM_FRAMES_C - used_frames);
            total_available <= bfa_pkg::COUNT_W'(snapshot);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BFA_ASSERT_ALWAYS(a_used_bound, clk, rst, used_frames <= NUM_FRAMES_C, "used count above frame count")
  `BFA_ASSERT_NEXT(a_idle_count_stable, clk, rst, state == S_IDLE, $stable(used_frames), "used count moved between commands")
  `BFA_ASSERT_IMPL(a_walk_in_range, clk, rst, state == S_RANGE_WR, widx <= last_word, "range walk ran past its last word")
  `BFA_ASSERT_IMPL(a_no_free_addr, clk, rst, out_valid && (status == bfa_pkg::ST_NO_FREE), frame_address == '0, "failed allocation returned an address")

endmodule

@@ design/bfa_word_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_word_update
// Modify stage of the bitmap read-modify-write: builds the bit mask, applies
// set or clear, counts flipped bits and finds the lowest free bit.
// ----------------------------------------------------------------------------
module bfa_word_update (
  input  bfa_pkg::word_t      old_word,
  input  bfa_pkg::word_op_t   op,
  output bfa_pkg::word_t      new_word,
  output bfa_pkg::word_info_t info
);

  bfa_pkg::word_t            mask;
  bfa_pkg::word_t            range_mask;
  bfa_pkg::word_t            diff;
  logic [bfa_pkg::BIT_W-1:0] first;
  logic [bfa_pkg::BIT_W:0]   cnt;

  // lowest zero bit
  always_comb begin
    first = '0;
    for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!old_word[i]) begin
        first = bfa_pkg::BIT_W'(i);
      end
    end
  end

  assign range_mask = (bfa_pkg::FULL_WORD << op.lo) &
                      (bfa_pkg::FULL_WORD >> (bfa_pkg::TOP_BIT - op.hi));
  assign mask       = op.first_fit ? (bfa_pkg::word_t'(1) << first) : range_mask;
  assign new_word   = op.set_bits ? (old_word | mask) : (old_word & ~mask);
  assign diff       = old_word ^ new_word;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < bfa_pkg::WORD_BITS; i++) begin
      cnt = cnt + (bfa_pkg::BIT_W + 1)'(diff[i]);
    end
  end

  assign info.has_free   = ~&old_word;
  assign info.first_free = first;
  assign info.flips      = cnt;

endmodule

@@ tb/tb_bitmap_frame_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator_core
// Self-checking bench for the first-fit bitmap frame allocator. Commands go in
// over a valid/ready channel. A local copy of the usage bitmap, the used-frame
// count and the snapshot register predicts every response, and each accepted
// response is compared field by field with the oldest prediction. Directed
// tests cover reset state, rejected frees, frame zero and the top frame, and
// range rounding, clamping and carry. A backpressure test stalls the response
// side for a long stretch. Random traffic then works a low window of frames,
// with some fully random noise, while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator_core;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_MAX     = 8;
  localparam int LONG_STALL   = 400;
  localparam int TAIL_CYCLES  = 64;
  localparam int TIMEOUT_NS   = 50_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int WIN_FRAMES   = 1024;   // random traffic works mostly here
  localparam int GUARD_FRAMES = 4096;   // free frames above the window

  localparam logic [bfa_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;   // 5..7 are unused

  typedef struct {
    logic [bfa_pkg::STATUS_W-1:0] status;
    logic [bfa_pkg::FADDR_W-1:0]  frame_addr;
    logic [bfa_pkg::COUNT_W-1:0]  free_frames;
    logic [bfa_pkg::COUNT_W-1:0]  avail_snapshot;
  } frame_response_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [bfa_pkg::CMD_W-1:0]    cmd;
  logic [bfa_pkg::ADDR_W-1:0]   address;
  logic [bfa_pkg::LEN_W-1:0]    length;
  logic                         out_valid;
  logic                         out_ready;
  logic [bfa_pkg::STATUS_W-1:0] status;
  logic [bfa_pkg::FADDR_W-1:0]  frame_address;
  logic [bfa_pkg::COUNT_W-1:0]  free_count;
  logic [bfa_pkg::COUNT_W-1:0]  total_available;

  // predicted allocator state
  bfa_pkg::word_t              frame_words [bfa_pkg::WORD_COUNT];
  int                          frames_in_use;
  logic [bfa_pkg::COUNT_W-1:0] snapshot_free;

  frame_response_t pending_responses [$];
  frame_response_t want;
  int              mismatch_count;
  bit              valid_held;
  bit              long_stall_req;
  int              send_gap_max;
  int              recv_gap_max;

  bitmap_frame_allocator_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .address         (address),
    .length          (length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .frame_address   (frame_address),
    .free_count      (free_count),
    .total_available (total_available)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [63:0] random_dword();
    return {$urandom, $urandom};
  endfunction

  function automatic void set_frame_usage(input logic [63:0] f, input bit used);
    if (frame_words[f >> bfa_pkg::BIT_W][f[bfa_pkg::BIT_W-1:0]] != used) begin
      frame_words[f >> bfa_pkg::BIT_W][f[bfa_pkg::BIT_W-1:0]] = used;
      frames_in_use += used ? 1 : -1;
    end
  endfunction

  function automatic frame_response_t compute_frame_response(
      input logic [bfa_pkg::CMD_W-1:0] op, input logic [bfa_pkg::ADDR_W-1:0] addr,
      input logic [bfa_pkg::LEN_W-1:0] len);
    frame_response_t          rsp;
    logic [bfa_pkg::ADDR_W:0] range_end;   // carry kept in the top bit
    logic [63:0]              first_frame;
    logic [63:0]              stop_frame;
    logic [63:0]              f;
    int                       w;
    int                       b;
    bit                       found;
    rsp.status     = bfa_pkg::ST_OK;
    rsp.frame_addr = '0;
    range_end = {1'b0, addr} + {1'b0, len};
    case (op)
      bfa_pkg::CMD_ALLOC: begin
        found = 1'b0;
        for (w = 0; w < bfa_pkg::WORD_COUNT && !found; w++) begin
          if (frame_words[w] != bfa_pkg::FULL_WORD) begin
            b = 0;
            while (frame_words[w][b]) b++;
            f = 64'(w) * bfa_pkg::WORD_BITS + 64'(b);
            set_frame_usage(f, 1'b1);
            rsp.frame_addr = bfa_pkg::FADDR_W'(f << bfa_pkg::FRAME_SHIFT);
            found = 1'b1;
          end
        end
        if (!found) rsp.status = bfa_pkg::ST_NO_FREE;
      end
      bfa_pkg::CMD_FREE: begin
        if (addr == 0 || addr[bfa_pkg::FRAME_SHIFT-1:0] != 0 ||
            (addr >> bfa_pkg::FRAME_SHIFT) >= bfa_pkg::NUM_FRAMES)
          rsp.status = bfa_pkg::ST_REJECT;
        else
          set_frame_usage(addr >> bfa_pkg::FRAME_SHIFT, 1'b0);
      end
      bfa_pkg::CMD_MARK_FREE, bfa_pkg::CMD_MARK_USED: begin
        // freeing takes whole frames only, marking used takes any overlap
        if (op == bfa_pkg::CMD_MARK_FREE) begin
          first_frame = (addr >> bfa_pkg::FRAME_SHIFT) +
                        64'(addr[bfa_pkg::FRAME_SHIFT-1:0] != 0);
          stop_frame  = range_end[bfa_pkg::ADDR_W-1:0] >> bfa_pkg::FRAME_SHIFT;
        end else begin
          first_frame = addr >> bfa_pkg::FRAME_SHIFT;
          stop_frame  = (range_end[bfa_pkg::ADDR_W-1:0] >> bfa_pkg::FRAME_SHIFT) +
                        64'(range_end[bfa_pkg::FRAME_SHIFT-1:0] != 0);
        end
        if (range_end[bfa_pkg::ADDR_W] || stop_frame > bfa_pkg::NUM_FRAMES)
          stop_frame = bfa_pkg::NUM_FRAMES;
        for (f = first_frame; f < stop_frame; f++)
          set_frame_usage(f, op == bfa_pkg::CMD_MARK_USED);
      end
      bfa_pkg::CMD_SNAPSHOT:
        snapshot_free = bfa_pkg::COUNT_W'(bfa_pkg::NUM_FRAMES - frames_in_use);
      default: ;
    endcase
    rsp.free_frames    = bfa_pkg::COUNT_W'(bfa_pkg::NUM_FRAMES - frames_in_use);
    rsp.avail_snapshot = snapshot_free;
    return rsp;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // valid stays up across back-to-back transactions; dropped only on a gap
  task automatic send_command(input logic [bfa_pkg::CMD_W-1:0] op,
                              input logic [bfa_pkg::ADDR_W-1:0] addr,
                              input logic [bfa_pkg::LEN_W-1:0] len);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      if (valid_held) in_valid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    address  <= addr;
    length   <= len;
    valid_held = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_responses.push_back(compute_frame_response(op, addr, len));
  endtask

  task automatic wait_for_drain;
    if (valid_held) in_valid <= 1'b0;
    valid_held = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // response side: random ready gaps after each transaction, or a long stall
  initial begin : response_sink
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold = LONG_STALL;
      end else if (out_valid && out_ready) begin
        hold = $urandom_range(recv_gap_max, 0);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        flag_mismatch("response with no command outstanding");
      end else begin
        want = pending_responses.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (frame_address !== want.frame_addr)
          flag_mismatch($sformatf("frame_address %h, want %h", frame_address, want.frame_addr));
        if (free_count !== want.free_frames)
          flag_mismatch($sformatf("free_count %0d, want %0d", free_count, want.free_frames));
        if (total_available !== want.avail_snapshot)
          flag_mismatch($sformatf("total_available %0d, want %0d",
                                  total_available, want.avail_snapshot));
      end
    end
  end

  // everything is used after reset, so allocation fails until something is freed
  task automatic test_after_reset;
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    send_command(bfa_pkg::CMD_FREE, '0, '0);
    send_command(bfa_pkg::CMD_FREE, 64'(7) * bfa_pkg::FRAME_BYTES + 3, '0);
    send_command(bfa_pkg::CMD_FREE, 64'(bfa_pkg::NUM_FRAMES) * bfa_pkg::FRAME_BYTES, '0);
    send_command(bfa_pkg::CMD_FREE, 64'(5) * bfa_pkg::FRAME_BYTES, '0);
    send_command(bfa_pkg::CMD_FREE, 64'(5) * bfa_pkg::FRAME_BYTES, '1);
    send_command(bfa_pkg::CMD_SNAPSHOT, '1, '1);
    send_command(bfa_pkg::CMD_ALLOC, '1, '1);
    for (int k = 0; k < 3; k++)
      send_command(CMD_SPARE_FIRST + bfa_pkg::CMD_W'(k), random_dword(), random_dword());
  endtask

  task automatic test_frame_zero_and_top;
    send_command(bfa_pkg::CMD_MARK_FREE, '0, 64'(bfa_pkg::FRAME_BYTES));
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
    send_command(bfa_pkg::CMD_FREE, 64'(bfa_pkg::NUM_FRAMES - 1) * bfa_pkg::FRAME_BYTES, '0);
    send_command(bfa_pkg::CMD_ALLOC, '0, '0);
  endtask

  task automatic test_range_edges;
    logic [bfa_pkg::ADDR_W-1:0] top_base;
    top_base = 64'(bfa_pkg::NUM_FRAMES - 64) * bfa_pkg::FRAME_BYTES;
    // partial frames at both ends
    send_command(bfa_pkg::CMD_MARK_FREE, 64'(10) * bfa_pkg::FRAME_BYTES + 1,
                 64'(3) * bfa_pkg::FRAME_BYTES);
    send_command(bfa_pkg::CMD_MARK_USED, 64'(11) * bfa_pkg::FRAME_BYTES + 5, 64'(10));
    // empty and inverted ranges
    send_command(bfa_pkg::CMD_MARK_FREE, 64'(30) * bfa_pkg::FRAME_BYTES, '0);
    send_command(bfa_pkg::CMD_MARK_FREE, 64'(20) * bfa_pkg::FRAME_BYTES + 1, 64'(100));
    // sum wraps past 64 bits or runs past the map: end clamps to the last frame
    send_command(bfa_pkg::CMD_MARK_FREE, top_base, '1);
    send_command(bfa_pkg::CMD_MARK_USED, top_base + 7, '1);
    send_command(bfa_pkg::CMD_MARK_FREE, 64'(bfa_pkg::NUM_FRAMES - 2) * bfa_pkg::FRAME_BYTES,
                 64'(100) * bfa_pkg::FRAME_BYTES);
    send_command(bfa_pkg::CMD_MARK_USED,
                 {{(bfa_pkg::ADDR_W - bfa_pkg::FRAME_SHIFT){1'b1}},
                  {bfa_pkg::FRAME_SHIFT{1'b0}}},
                 64'(bfa_pkg::FRAME_BYTES));
    // whole map free, then whole map used
    send_command(bfa_pkg::CMD_MARK_FREE, '0, '1);
    send_command(bfa_pkg::CMD_SNAPSHOT, '0, '0);
    send_command(bfa_pkg::CMD_MARK_USED, '0, '1);
    send_command(bfa_pkg::CMD_SNAPSHOT, '0, '0);
  endtask

  // responses held off long enough that the core stops taking commands
  task automatic test_backpressure;
    send_gap_max = 0;
    long_stall_req = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 0)
        send_command(bfa_pkg::CMD_FREE, 64'(40 + k) * bfa_pkg::FRAME_BYTES, '0);
      else if (k % 3 == 1)
        send_command(bfa_pkg::CMD_ALLOC, '0, '0);
      else
        send_command(bfa_pkg::CMD_SNAPSHOT, '0, '0);
    end
    wait_for_drain;
    send_gap_max = IDLE_MAX;
  endtask

  task automatic test_random_traffic;
    logic [bfa_pkg::CMD_W-1:0]  op;
    logic [bfa_pkg::ADDR_W-1:0] addr;
    logic [bfa_pkg::LEN_W-1:0]  len;
    int                         pick;
    send_command(bfa_pkg::CMD_MARK_FREE, 64'(WIN_FRAMES) * bfa_pkg::FRAME_BYTES,
                 64'(GUARD_FRAMES) * bfa_pkg::FRAME_BYTES);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        send_gap_max = $urandom_range(1) ? IDLE_MAX : 0;
        recv_gap_max = $urandom_range(1) ? IDLE_MAX : 0;
      end
      if (n % 300 == 299) wait_for_drain;
      pick = $urandom_range(99);
      addr = '0;
      len  = '0;
      if (pick < 30) begin
        op = bfa_pkg::CMD_ALLOC;
      end else if (pick < 55) begin
        op = bfa_pkg::CMD_FREE;
        addr = 64'($urandom_range(pick < 50 ? WIN_FRAMES - 1
                                            : WIN_FRAMES + GUARD_FRAMES - 1))
               << bfa_pkg::FRAME_SHIFT;
        if ($urandom_range(9) == 0)
          addr[bfa_pkg::FRAME_SHIFT-1:0] = bfa_pkg::FRAME_SHIFT'($urandom);
      end else if (pick < 77) begin
        op = (pick < 67) ? bfa_pkg::CMD_MARK_FREE : bfa_pkg::CMD_MARK_USED;
        addr = 64'($urandom_range(WIN_FRAMES * bfa_pkg::FRAME_BYTES - 1));
        if ($urandom_range(1)) addr[bfa_pkg::FRAME_SHIFT-1:0] = '0;
        len = 64'($urandom_range(op == bfa_pkg::CMD_MARK_FREE ? 64 * bfa_pkg::FRAME_BYTES
                                                              : 16 * bfa_pkg::FRAME_BYTES));
        if ($urandom_range(1)) len[bfa_pkg::FRAME_SHIFT-1:0] = '0;
      end else if (pick < 87) begin
        op = bfa_pkg::CMD_SNAPSHOT;
      end else begin
        // noise: any code, full-width fields
        op   = bfa_pkg::CMD_W'($urandom);
        addr = random_dword();
        len  = random_dword();
      end
      send_command(op, addr, len);
    end
  endtask

  initial begin
    for (int w = 0; w < bfa_pkg::WORD_COUNT; w++) frame_words[w] = bfa_pkg::FULL_WORD;
    frames_in_use  = bfa_pkg::NUM_FRAMES;
    snapshot_free  = '0;
    mismatch_count = 0;
    valid_held     = 1'b0;
    long_stall_req = 1'b0;
    send_gap_max   = IDLE_MAX;
    recv_gap_max   = IDLE_MAX;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    cmd      <= bfa_pkg::CMD_ALLOC;
    address  <= '0;
    length   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_after_reset;
    test_frame_zero_and_top;
    test_range_edges;
    test_backpressure;
    test_random_traffic;

    wait_for_drain;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_responses.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
